FILE: src/msf_pkg.sv
`timescale 1ns / 1ps
package msf_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int MAX_BYTES_DEF = 64;
   localparam int CQ_DEPTH      = 4;

   localparam int OP_W   = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 7;

   localparam logic [OP_W-1:0] OP_SEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_RECV  = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAN = 3'd4;

   localparam int              CSR_ADDR_W       = 2;
   localparam logic [1:0]      CSR_MAX_MSG_ADDR = 2'd0;
   localparam logic [CNT_W-1:0] MAX_MSG_RESET   = 7'd64;

   // what the front hands the back for one item
   typedef struct packed {
      logic              is_stream;
      logic              ok;
      logic              q_empty;
      logic              q_full;
      logic [BYTE_W-1:0] bsize;
   } cmd_flags_type;

   localparam int CMD_FLAGS_W = $bits(cmd_flags_type);

endpackage

FILE: src/msf_cmd_queue.sv
`timescale 1ns / 1ps
module msf_cmd_queue
   import msf_pkg::*;
#(
   parameter int W = 8,
   parameter int DEPTH = CQ_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_QW = $clog2(DEPTH + 1)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  logic [W-1:0] wr_data,
   output logic         q_full,
   input  logic         rd_en,
   output logic         q_valid,
   output logic [W-1:0] rd_data
);

   logic [W-1:0]      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign q_full  = (count_ff == CNT_QW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/msf_front.sv
`timescale 1ns / 1ps
module msf_front
   import msf_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int ADDR_W = (SLOTS * MAX_BYTES > 1) ? $clog2(SLOTS * MAX_BYTES) : 1,
   localparam int SCNT_W = $clog2(CQ_DEPTH + 2)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [OP_W-1:0]   op,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [BYTE_W-1:0] msg_len,
   input  logic              last_byte,
   input  logic [BYTE_W-1:0] rx_capacity,
   input  logic [CNT_W-1:0]  max_msg_bytes,
   input  logic              cq_full,
   input  logic              stream_done,
   output logic              cq_push,
   output cmd_flags_type     cq_flags,
   output logic [SLOT_W-1:0] cq_slot,
   output logic              st_we,
   output logic [ADDR_W-1:0] st_addr,
   output logic [BYTE_W-1:0] st_data,
   output logic              len_we,
   output logic [SLOT_W-1:0] len_slot,
   output logic [CNT_W-1:0]  len_data
);

   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              active_ff, active_in;
   logic              drop_ff, drop_in;
   logic [SCNT_W-1:0] stream_cnt_ff, stream_cnt_in;

   logic              accept, cur_empty, cur_full, drop_cur, do_store;
   logic [CNT_W-1:0]  limit, cap, fill_cur, fill_new;

   function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   // a send byte waits until no stream is in flight, so it never lands in a slot being read
   assign full   = cq_full || (op == OP_SEND && stream_cnt_ff != '0);
   assign accept = push && !full;

   assign cur_empty = (read_slot_ff == write_slot_ff);
   assign cur_full  = (nxt(write_slot_ff) == read_slot_ff);

   assign limit = (max_msg_bytes > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : max_msg_bytes;
   assign cap   = (msg_len > BYTE_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : msg_len[CNT_W-1:0];

   assign drop_cur = active_ff ? drop_ff : (cur_full || (msg_len > {1'b0, limit}));
   assign fill_cur = active_ff ? fill_ff : '0;
   assign do_store = !drop_cur && (fill_cur < cap);
   assign fill_new = do_store ? fill_cur + 1'b1 : fill_cur;

   assign st_addr  = ADDR_W'(int'(write_slot_ff) * MAX_BYTES + int'(fill_cur));
   assign st_data  = data_byte;
   assign len_slot = write_slot_ff;
   assign len_data = fill_new;
   assign cq_slot  = read_slot_ff;

   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      drop_in       = drop_ff;
      st_we         = 1'b0;
      len_we        = 1'b0;
      cq_push       = 1'b0;
      cq_flags      = '0;
      if (accept) begin
         cq_push        = 1'b1;
         cq_flags.bsize = rx_capacity;
         case (op)
            OP_SEND: begin
               st_we       = do_store;
               cq_flags.ok = !drop_cur;
               if (last_byte) begin
                  if (!drop_cur) begin
                     len_we        = 1'b1;
                     write_slot_in = nxt(write_slot_ff);
                  end
                  active_in = 1'b0;
                  drop_in   = 1'b0;
                  fill_in   = '0;
               end else begin
                  active_in = 1'b1;
                  drop_in   = drop_cur;
                  fill_in   = fill_new;
               end
            end
            OP_RECV, OP_PEEK: begin
               if (!cur_empty) begin
                  cq_flags.is_stream = 1'b1;
                  cq_flags.ok        = 1'b1;
                  if (op == OP_RECV) begin
                     read_slot_in = nxt(read_slot_ff);
                  end
               end
            end
            OP_POP: begin
               if (!cur_empty) begin
                  cq_flags.ok  = 1'b1;
                  read_slot_in = nxt(read_slot_ff);
               end
            end
            OP_CLEAN: begin
               cq_flags.ok  = 1'b1;
               read_slot_in = write_slot_ff;
            end
            default: begin
               cq_flags.ok = 1'b0;
            end
         endcase
         cq_flags.q_empty = (read_slot_in == write_slot_in);
         cq_flags.q_full  = (nxt(write_slot_in) == read_slot_in);
      end
   end

   always_comb begin
      stream_cnt_in = stream_cnt_ff;
      if (cq_push && cq_flags.is_stream && !stream_done) begin
         stream_cnt_in = stream_cnt_ff + 1'b1;
      end else if (stream_done && !(cq_push && cq_flags.is_stream)) begin
         stream_cnt_in = stream_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         active_ff     <= 1'b0;
         drop_ff       <= 1'b0;
         stream_cnt_ff <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         active_ff     <= active_in;
         drop_ff       <= drop_in;
         stream_cnt_ff <= stream_cnt_in;
      end
   end

endmodule

FILE: src/msf_back.sv
`timescale 1ns / 1ps
module msf_back
   import msf_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int DEPTH = SLOTS * MAX_BYTES,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cq_valid,
   input  cmd_flags_type     cq_flags,
   input  logic [SLOT_W-1:0] cq_slot,
   output logic              cq_pop,
   input  logic              st_we,
   input  logic [ADDR_W-1:0] st_addr,
   input  logic [BYTE_W-1:0] st_data,
   input  logic              len_we,
   input  logic [SLOT_W-1:0] len_slot,
   input  logic [CNT_W-1:0]  len_data,
   output logic              stream_done,
   input  logic              pop,
   output logic              empty,
   output logic              rsp_ok,
   output logic              rsp_has_data,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [CNT_W-1:0]  rsp_byte_count,
   output logic              rsp_run_end,
   output logic              rsp_queue_empty,
   output logic              rsp_queue_full
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;
   localparam logic [1:0] ST_LD   = 2'd3;

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [CNT_W-1:0]  len_mem [SLOTS];
   logic [BYTE_W-1:0] store_q_ff;
   logic [CNT_W-1:0]  len_q_ff;

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   cmd_flags_type     flags_ff, flags_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;

   logic              valid_ff, valid_in;
   logic              ok_ff, ok_in, hd_ff, hd_in, end_ff, end_in;
   logic              qe_ff, qe_in, qf_ff, qf_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              out_free;
   logic [CNT_W-1:0]  len_cut, cnt_cur;
   logic [ADDR_W-1:0] rd_addr;

   assign out_free = !valid_ff || pop;
   assign len_cut  = (len_q_ff > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : len_q_ff;
   assign cnt_cur  = ({1'b0, len_cut} < flags_ff.bsize) ? len_cut
                                                        : flags_ff.bsize[CNT_W-1:0];
   assign rd_addr  = ADDR_W'(int'(slot_ff) * MAX_BYTES + int'(idx_ff));

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      flags_in    = flags_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      cq_pop      = 1'b0;
      stream_done = 1'b0;
      valid_in    = valid_ff && !pop;
      ok_in       = ok_ff;
      hd_in       = hd_ff;
      byte_in     = byte_ff;
      count_in    = count_ff;
      end_in      = end_ff;
      qe_in       = qe_ff;
      qf_in       = qf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cq_valid && cq_flags.is_stream) begin
               cq_pop   = 1'b1;
               slot_in  = cq_slot;
               flags_in = cq_flags;
               state_in = ST_LEN;
            end else if (cq_valid && out_free) begin
               cq_pop   = 1'b1;
               valid_in = 1'b1;
               ok_in    = cq_flags.ok;
               hd_in    = 1'b0;
               byte_in  = '0;
               count_in = '0;
               end_in   = 1'b1;
               qe_in    = cq_flags.q_empty;
               qf_in    = cq_flags.q_full;
            end
         end
         ST_LEN: begin
            if (cnt_cur != '0) begin
               cnt_in   = cnt_cur;
               idx_in   = '0;
               state_in = ST_RD;
            end else if (out_free) begin
               // nothing to deliver: one plain success result
               stream_done = 1'b1;
               valid_in    = 1'b1;
               ok_in       = 1'b1;
               hd_in       = 1'b0;
               byte_in     = '0;
               count_in    = '0;
               end_in      = 1'b1;
               qe_in       = flags_ff.q_empty;
               qf_in       = flags_ff.q_full;
               state_in    = ST_IDLE;
            end
         end
         ST_RD: begin
            // store read goes out this cycle; output is empty by the next one
            if (out_free) begin
               state_in = ST_LD;
            end
         end
         ST_LD: begin
            valid_in = 1'b1;
            ok_in    = 1'b1;
            hd_in    = 1'b1;
            byte_in  = store_q_ff;
            count_in = cnt_ff;
            end_in   = (idx_ff == cnt_ff - 1'b1);
            qe_in    = flags_ff.q_empty;
            qf_in    = flags_ff.q_full;
            if (idx_ff == cnt_ff - 1'b1) begin
               stream_done = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      flags_ff <= flags_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      hd_ff    <= hd_in;
      byte_ff  <= byte_in;
      count_ff <= count_in;
      end_ff   <= end_in;
      qe_ff    <= qe_in;
      qf_ff    <= qf_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_addr] <= st_data;
      end
      store_q_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_slot] <= len_data;
      end
      // length of the head command; held while that command is worked on
      if (state_ff == ST_IDLE) begin
         len_q_ff <= len_mem[cq_slot];
      end
   end

   assign empty           = !valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_has_data    = hd_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_run_end     = end_ff;
   assign rsp_queue_empty = qe_ff;
   assign rsp_queue_full  = qf_ff;

endmodule

FILE: src/message_slot_fifo.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Item moves when
// -------   -------------------------------------  ------------------------------------
// request   push/full, req_* fields                push && !full at rising edge
// response  empty/pop, rsp_* fields                pop && !empty at rising edge
// config    psel/penable/pwrite/paddr/pwdata/...   psel && penable && pwrite && pready
//
// Send, pop, clean and undefined ops: one item per cycle, one response each, while the
// 4-entry command queue between front and back has room.
// Recv/peek: the back takes the command and reads the slot length, then moves each byte
// through a registered store read and then an output load.
// A send byte is held off (full) while any recv/peek stream is still in flight.
// Synchronous reset clears pointers, send state, queue and output; stores are not cleared.
module message_slot_fifo
   import msf_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  logic [OP_W-1:0]       req_op,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic [BYTE_W-1:0]     req_msg_len,
   input  logic                  req_last_byte,
   input  logic [BYTE_W-1:0]     req_rx_capacity,
   // response channel
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_ok,
   output logic                  rsp_has_data,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [CNT_W-1:0]      rsp_byte_count,
   output logic                  rsp_run_end,
   output logic                  rsp_queue_empty,
   output logic                  rsp_queue_full,
   // config port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ADDR_W = (SLOTS * MAX_BYTES > 1) ? $clog2(SLOTS * MAX_BYTES) : 1;
   localparam int CMD_W  = CMD_FLAGS_W + SLOT_W;

   // max_msg_bytes register
   logic [CNT_W-1:0] max_msg_ff, max_msg_in;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_MAX_MSG_ADDR);
   assign max_msg_in = csr_wr ? pwdata[CNT_W-1:0] : max_msg_ff;
   assign prdata = (paddr == CSR_MAX_MSG_ADDR) ? {{(32 - CNT_W){1'b0}}, max_msg_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff <= MAX_MSG_RESET;
      end else begin
         max_msg_ff <= max_msg_in;
      end
   end

   // front -> queue -> back
   logic              cq_push, cq_full, cq_valid, cq_pop, stream_done;
   cmd_flags_type     fr_flags, bk_flags;
   logic [SLOT_W-1:0] fr_slot, bk_slot;
   logic [CMD_W-1:0]  cq_rd_data;
   logic              st_we, len_we;
   logic [ADDR_W-1:0] st_addr;
   logic [BYTE_W-1:0] st_data;
   logic [SLOT_W-1:0] len_slot;
   logic [CNT_W-1:0]  len_data;

   msf_front #(
      .SLOTS     (SLOTS),
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .op            (req_op),
      .data_byte     (req_data_byte),
      .msg_len       (req_msg_len),
      .last_byte     (req_last_byte),
      .rx_capacity   (req_rx_capacity),
      .max_msg_bytes (max_msg_ff),
      .cq_full       (cq_full),
      .stream_done   (stream_done),
      .cq_push       (cq_push),
      .cq_flags      (fr_flags),
      .cq_slot       (fr_slot),
      .st_we         (st_we),
      .st_addr       (st_addr),
      .st_data       (st_data),
      .len_we        (len_we),
      .len_slot      (len_slot),
      .len_data      (len_data)
   );

   msf_cmd_queue #(
      .W     (CMD_W),
      .DEPTH (CQ_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cq_push),
      .wr_data ({fr_flags, fr_slot}),
      .q_full  (cq_full),
      .rd_en   (cq_pop),
      .q_valid (cq_valid),
      .rd_data (cq_rd_data)
   );

   assign bk_flags = cmd_flags_type'(cq_rd_data[CMD_W-1:SLOT_W]);
   assign bk_slot  = cq_rd_data[SLOT_W-1:0];

   msf_back #(
      .SLOTS     (SLOTS),
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cq_valid        (cq_valid),
      .cq_flags        (bk_flags),
      .cq_slot         (bk_slot),
      .cq_pop          (cq_pop),
      .st_we           (st_we),
      .st_addr         (st_addr),
      .st_data         (st_data),
      .len_we          (len_we),
      .len_slot        (len_slot),
      .len_data        (len_data),
      .stream_done     (stream_done),
      .pop             (pop),
      .empty           (empty),
      .rsp_ok          (rsp_ok),
      .rsp_has_data    (rsp_has_data),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_run_end     (rsp_run_end),
      .rsp_queue_empty (rsp_queue_empty),
      .rsp_queue_full  (rsp_queue_full)
   );

endmodule

FILE: src/msf_checker.sv
`timescale 1ns / 1ps
module msf_checker
   import msf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              pop,
   input logic              empty,
   input logic              rsp_ok,
   input logic              rsp_has_data,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic [CNT_W-1:0]  rsp_byte_count,
   input logic              rsp_queue_empty,
   input logic              rsp_queue_full
);

   // no response survives a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response pending after reset");

   // a data byte only comes with success and a nonzero count
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_has_data) |-> (rsp_ok && rsp_byte_count != '0))
      else $error("data byte without ok or count");

   // results without data carry a zero byte and zero count
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_has_data) |-> (rsp_out_byte == '0 && rsp_byte_count == '0))
      else $error("stray byte or count on a result without data");

   // ring can't be empty and full at once
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_queue_empty && rsp_queue_full))
      else $error("queue both empty and full");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_byte_count)))
      else $error("stalled response changed");

endmodule

bind message_slot_fifo msf_checker u_msf_checker (
   .clock           (clock),
   .reset           (reset),
   .pop             (pop),
   .empty           (empty),
   .rsp_ok          (rsp_ok),
   .rsp_has_data    (rsp_has_data),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_queue_empty (rsp_queue_empty),
   .rsp_queue_full  (rsp_queue_full)
);
